// File: sv/bba_pkg.sv
// Shared types and constants of the bitmap block allocator.
package bba_pkg;

  // Configuration values and counts are 13 bits wide; request and result block numbers 12
  localparam int unsigned BLK_W   = 13;
  localparam int unsigned FBLK_W  = 12;
  localparam int unsigned BLK_MAX = 8191;

  // Configuration register indexes
  localparam logic REG_TOTAL_BLOCKS = 1'b0;
  localparam logic REG_DATA_START   = 1'b1;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_DBL_FREE = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  typedef struct packed {
    logic              kind;
    logic [FBLK_W-1:0] free_block;
  } req_t;

  typedef struct packed {
    logic [BLK_W-1:0]  free_count;
    logic [FBLK_W-1:0] granted_block;
    status_e           status;
  } res_t;

endpackage

// File: sv/bitmap_block_allocator_top.sv
// Top level of the bitmap block allocator: stream ports, APB registers, result register.
// First-fit block allocator over a bitmap of one used bit per block, held in a
// synchronous memory of WORD_BITS-wide words (128 words at the default size).
// After reset the block sweeps the memory clear, one word a cycle, and accepts
// no request until the sweep is done; configuration writes are taken throughout.
// A request is taken on the stream slave side, tuser carrying the kind (0
// allocate, 1 free) and tdata the block to free. A free passes through the
// divide, bit check and result states; an allocation passes through the divide
// state, then the scan state, which examines one bitmap word per cycle, then
// the result state. Requests that fail the range checks go from idle straight
// to the result state. One request is worked on at a time; a finished result
// waits in the output register while the next request is taken.
module bitmap_block_allocator_top import bba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = 4096,
  parameter int unsigned WORD_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [11:0] free_block, [15:12] zero
  input  logic [0:0]  s_axis_tuser,  // [0] kind
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [1:0] status, [13:2] granted_block,
                                     // [26:14] free_count, [31:27] zero
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned TOTAL_RST = (MAX_BLOCKS > BLK_MAX) ? BLK_MAX : MAX_BLOCKS;

  logic [BLK_W-1:0] total_blocks;
  logic [BLK_W-1:0] data_start;
  req_t             req;
  logic             res_valid;
  logic             res_take;
  res_t             res;
  logic             out_valid_q, out_valid_d;
  res_t             out_q;

  bba_cfg #(
    .TOTAL_RST (TOTAL_RST)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .total_blocks_o (total_blocks),
    .data_start_o   (data_start)
  );

  assign req.kind       = s_axis_tuser[0];
  assign req.free_block = s_axis_tdata[FBLK_W-1:0];

  bba_core #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (s_axis_tvalid),
    .req_ready_o    (s_axis_tready),
    .req_i          (req),
    .total_blocks_i (total_blocks),
    .data_start_i   (data_start),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_take),
    .res_o          (res)
  );

  // output register: load when empty or being drained
  assign res_take = res_valid && (!out_valid_q || m_axis_tready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q.free_count, out_q.granted_block, out_q.status};

endmodule

// File: sv/bba_cfg.sv
// APB configuration registers: total block count and data start.
module bba_cfg import bba_pkg::*; #(
  parameter int unsigned TOTAL_RST = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [BLK_W-1:0] total_blocks_o,
  output logic [BLK_W-1:0] data_start_o
);

  logic [BLK_W-1:0] total_q, total_d;
  logic [BLK_W-1:0] start_q, start_d;
  logic             wr_en;
  logic             reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];

  // register write decode
  always_comb begin
    total_d = total_q;
    start_d = start_q;
    if (wr_en) begin
      case (reg_idx)
        REG_TOTAL_BLOCKS: total_d = pwdata[BLK_W-1:0];
        REG_DATA_START:   start_d = pwdata[BLK_W-1:0];
        default:          total_d = total_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= BLK_W'(TOTAL_RST);
      start_q <= '0;
    end else begin
      total_q <= total_d;
      start_q <= start_d;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_TOTAL_BLOCKS: prdata = {{(32-BLK_W){1'b0}}, total_q};
      REG_DATA_START:   prdata = {{(32-BLK_W){1'b0}}, start_q};
      default:          prdata = '0;
    endcase
  end

  assign total_blocks_o = total_q;
  assign data_start_o   = start_q;

endmodule

// File: sv/bba_core.sv
// Allocator core: bitmap memory, clearing pass and word-by-word first-fit scan.
module bba_core import bba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = 4096,
  parameter int unsigned WORD_BITS  = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  req_t             req_i,
  input  logic [BLK_W-1:0] total_blocks_i,
  input  logic [BLK_W-1:0] data_start_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o
);

  // reachable blocks never exceed what a 13 bit total can describe
  localparam int unsigned LIM   = (MAX_BLOCKS > BLK_MAX) ? BLK_MAX : MAX_BLOCKS;
  localparam int unsigned DEPTH = (LIM + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IW    = $clog2(WORD_BITS);
  localparam int unsigned BW    = BLK_W + 1;
  // word index by reciprocal multiply, exact for any 13 bit block number
  localparam int unsigned SH    = BLK_W + IW;
  localparam int unsigned RECIP = (1 << SH) / WORD_BITS + 1;
  localparam int unsigned RW    = $clog2(RECIP + 1);
  localparam int unsigned PW    = BLK_W + RW;

  localparam logic [RW-1:0] RECIP_V = RW'(RECIP);
  localparam logic [BW-1:0] WB      = BW'(WORD_BITS);
  localparam logic [AW-1:0] LAST_W  = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_V = (AW+1)'(DEPTH);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DIV   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_FCHK  = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic [BLK_W-1:0]     alloc_q, alloc_d;
  logic                 kind_q, kind_d;
  logic [BLK_W-1:0]     x_q, x_d;
  logic [PW-1:0]        prod_q, prod_d;
  logic [AW-1:0]        word_q, word_d;
  logic [BW-1:0]        base_q, base_d;
  status_e              st_q, st_d;
  logic [BLK_W-1:0]     grant_q, grant_d;

  // bitmap memory
  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic [BLK_W-1:0]     end_blk;
  logic [BLK_W-1:0]     span;
  logic [BLK_W-1:0]     free_cnt;
  logic [AW-1:0]        div_word;
  logic [AW:0]          next_word;
  logic [WORD_BITS-1:0] in_span;
  logic [WORD_BITS-1:0] cand;
  logic [IW-1:0]        idx;
  logic [BW-1:0]        pos;
  logic [BW-1:0]        diff;
  logic [IW-1:0]        off;
  logic [BW-1:0]        base_nxt;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // search end and free count
  assign end_blk  = (total_blocks_i < BLK_W'(LIM)) ? total_blocks_i : BLK_W'(LIM);
  assign span     = (data_start_i < end_blk) ? end_blk - data_start_i : '0;
  assign free_cnt = (span > alloc_q) ? span - alloc_q : '0;

  assign div_word  = prod_q[SH +: AW];
  assign next_word = {1'b0, word_q} + (AW+1)'(1);
  assign base_nxt  = base_q + WB;

  // bits of the current word inside [data_start, end)
  always_comb begin
    in_span = '0;
    pos     = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      pos        = base_q + BW'(i);
      in_span[i] = (pos >= {1'b0, data_start_i}) && (pos < {1'b0, end_blk});
    end
  end

  assign cand = ~rdata_q & in_span;

  // lowest free candidate
  always_comb begin
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        idx = IW'(i);
      end
    end
  end

  assign diff = {1'b0, x_q} - base_q;
  assign off  = diff[IW-1:0];

  // sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    alloc_d = alloc_q;
    kind_d  = kind_q;
    x_d     = x_q;
    prod_d  = prod_q;
    word_d  = word_q;
    base_d  = base_q;
    st_d    = st_q;
    grant_d = grant_q;
    rd_en   = 1'b0;
    rd_addr = div_word;
    wr_en   = 1'b0;
    wr_addr = word_q;
    wr_data = rdata_q;
    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + AW'(1);
        if (clr_q == LAST_W) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          kind_d  = req_i.kind;
          st_d    = ST_OK;
          grant_d = '0;
          if (req_i.kind == KIND_FREE) begin
            x_d = {1'b0, req_i.free_block};
            if ({1'b0, req_i.free_block} >= end_blk) begin
              st_d    = ST_RANGE;
              state_d = S_RESP;
            end else begin
              state_d = S_DIV;
            end
          end else begin
            x_d = data_start_i;
            if (data_start_i >= end_blk) begin
              st_d    = ST_NO_FREE;
              state_d = S_RESP;
            end else begin
              state_d = S_DIV;
            end
          end
          prod_d = PW'(x_d) * PW'(RECIP_V);
        end
      end
      S_DIV: begin
        word_d  = div_word;
        base_d  = BW'(div_word) * WB;
        rd_en   = 1'b1;
        rd_addr = div_word;
        state_d = (kind_q == KIND_FREE) ? S_FCHK : S_SCAN;
      end
      S_FCHK: begin
        if (!rdata_q[off]) begin
          st_d = ST_DBL_FREE;
        end else begin
          wr_en   = 1'b1;
          wr_data = rdata_q & ~(WORD_BITS'(1) << off);
          if (alloc_q != '0) begin
            alloc_d = alloc_q - BLK_W'(1);
          end
        end
        state_d = S_RESP;
      end
      S_SCAN: begin
        // fetch the following word while this one is examined
        rd_addr = next_word[AW-1:0];
        rd_en   = next_word < DEPTH_V;
        if (cand != '0) begin
          wr_en   = 1'b1;
          wr_data = rdata_q | (WORD_BITS'(1) << idx);
          alloc_d = alloc_q + BLK_W'(1);
          grant_d = BLK_W'(base_q + BW'(idx));
          state_d = S_RESP;
        end else if (base_nxt >= {1'b0, end_blk}) begin
          st_d    = ST_NO_FREE;
          state_d = S_RESP;
        end else begin
          word_d = next_word[AW-1:0];
          base_d = base_nxt;
        end
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      alloc_q <= '0;
      kind_q  <= KIND_ALLOC;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      alloc_q <= alloc_d;
      kind_q  <= kind_d;
      st_q    <= st_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    prod_q  <= prod_d;
    word_q  <= word_d;
    base_q  <= base_d;
    grant_q <= grant_d;
  end

  assign req_ready_o         = (state_q == S_IDLE);
  assign res_valid_o         = (state_q == S_RESP);
  assign res_o.status        = st_q;
  assign res_o.granted_block = grant_q[FBLK_W-1:0];
  assign res_o.free_count    = free_cnt;

endmodule
